### rtl/core/gpcs_pkg.sv
// shared constants and types for the partition cut statistics unit
`timescale 1ns / 1ps
`default_nettype none
package gpcs_pkg;
  localparam int MaxPartsDefault = 64;
  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

  // per-part counters travelling along the chain
  typedef struct packed {
    logic [31:0] vertices;
    logic [31:0] internal;
    logic [31:0] outgoing;
    logic [31:0] incoming;
    logic [63:0] wout;
    logic [63:0] win;
  } part_rec_t;

  // update request broadcast to every cell
  typedef struct packed {
    logic        vtx;
    logic        edge_int;
    logic        cut_edge;
    logic        clr;
    logic        rot;
    logic [5:0]  p;
    logic [5:0]  s;
    logic [5:0]  d;
    logic [63:0] w;
  } cell_cmd_t;

  function automatic logic [31:0] inc32(input logic [31:0] a);
    return (a == Max32) ? a : a + 32'd1;
  endfunction

  function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Max32 : s[31:0];
  endfunction

  function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (((a ^ r) & (b ^ r)) >> 63 != 64'd0)
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/core/graph_partition_cut_stats_unit.sv
// top level: chain of per-part cells, report scan and apb register
// vertex, edge and clear requests are applied directly; busy stays low for them
// a report rotates the chain once: busy is high through the scan and done states and the
// summary is strobed for one cycle once busy is low again; no stall
// rst is synchronous: it zeroes all counters, part_count and the controller
// clear zeroes the store and keeps part_count
`timescale 1ns / 1ps
`default_nettype none
module graph_partition_cut_stats_unit #(
  parameter int MAX_PARTS = gpcs_pkg::MaxPartsDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  op,
  input  wire  [5:0]  part_id,
  input  wire  [5:0]  src_part,
  input  wire  [5:0]  dest_part,
  input  wire  [31:0] weight,
  output logic        strobe,
  output logic [6:0]  parts_used,
  output logic [31:0] vertex_total,
  output logic [31:0] edge_total,
  output logic [31:0] cut_total,
  output logic [63:0] weighted_cut_total,
  output logic [31:0] local_cut_peak,
  output logic [63:0] weighted_local_cut_peak,
  output logic [31:0] least_vertices,
  output logic [31:0] most_vertices,
  output logic [31:0] least_edge_load,
  output logic [31:0] most_edge_load,
  output logic        part_error
);
  import gpcs_pkg::*;
  localparam int IdxW = $clog2(MAX_PARTS);
  localparam int CntW = IdxW + 1;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [6:0] part_count;
  logic [1:0] state;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] rot_ofs;
  cell_cmd_t cmd;
  part_rec_t recs [MAX_PARTS];
  logic [31:0] cut_count, vertex_count, edge_tally;
  logic [63:0] cut_weight_sum;
  logic [6:0] highest;
  logic err_flag;
  logic acc, in_range, big_p, big_s, big_d;
  logic [6:0] used, hi_next;
  logic used_err;
  logic [31:0] lc, es;
  logic [63:0] wlc;

  assign pready = 1'b1;
  assign prdata = {25'd0, part_count};
  always_ff @(posedge clk) begin
    if (rst) part_count <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) part_count <= pwdata[6:0];
  end

  assign busy = (state != ST_IDLE);
  assign acc  = start && !busy;
  assign big_p = 32'(part_id) >= 32'(MAX_PARTS);
  assign big_s = 32'(src_part) >= 32'(MAX_PARTS);
  assign big_d = 32'(dest_part) >= 32'(MAX_PARTS);
  assign in_range = (op == OP_VERTEX) ? !big_p : !(big_s || big_d);

  always_comb begin
    cmd          = '0;
    cmd.p        = part_id;
    cmd.s        = src_part;
    cmd.d        = dest_part;
    cmd.w        = {{32{weight[31]}}, weight};
    cmd.vtx      = acc && op == OP_VERTEX && !big_p;
    cmd.edge_int = acc && op == OP_EDGE && in_range && src_part == dest_part;
    cmd.cut_edge = acc && op == OP_EDGE && in_range && src_part != dest_part;
    cmd.clr      = rst || (acc && op == OP_CLEAR);
    cmd.rot      = (state == ST_SCAN);
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PARTS; g++) begin : g_cell
      gpcs_cell #(.IdxW(IdxW), .Idx(g)) u_cell (
        .clk(clk), .cmd(cmd), .rot_ofs(rot_ofs),
        .prev(recs[(g + 1) % MAX_PARTS]), .rec(recs[g])
      );
    end
  endgenerate

  always_comb begin
    hi_next = highest;
    if (op == OP_VERTEX) begin
      if ({1'b0, part_id} + 7'd1 > hi_next) hi_next = {1'b0, part_id} + 7'd1;
    end else begin
      if ({1'b0, src_part} + 7'd1 > hi_next) hi_next = {1'b0, src_part} + 7'd1;
      if ({1'b0, dest_part} + 7'd1 > hi_next) hi_next = {1'b0, dest_part} + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      cut_count <= '0; vertex_count <= '0; edge_tally <= '0;
      cut_weight_sum <= '0; highest <= '0; err_flag <= 1'b0;
    end else if (acc && (op == OP_VERTEX || op == OP_EDGE)) begin
      if (!in_range) begin
        err_flag <= 1'b1;
      end else begin
        highest <= hi_next;
        if (op == OP_VERTEX) begin
          vertex_count <= inc32(vertex_count);
        end else begin
          edge_tally <= inc32(edge_tally);
          if (src_part != dest_part) begin
            cut_count      <= inc32(cut_count);
            cut_weight_sum <= sadd64(cut_weight_sum, cmd.w);
          end
        end
      end
    end
  end

  always_comb begin
    used_err = 1'b0;
    if (part_count != 7'd0) begin
      used = part_count;
      if (32'(part_count) > 32'(MAX_PARTS)) begin
        used = 7'(MAX_PARTS);
        used_err = 1'b1;
      end
      if (highest > part_count) used_err = 1'b1;
    end else begin
      used = highest;
    end
    if (used == 7'd0) used_err = 1'b1;
  end

  // head cell presents part cnt during the scan
  assign lc  = add32(recs[0].outgoing, recs[0].incoming);
  assign es  = add32(recs[0].internal, lc);
  assign wlc = sadd64(recs[0].wout, recs[0].win);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cnt <= '0; rot_ofs <= '0; strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc && op == OP_REPORT) begin
            state <= ST_SCAN; cnt <= '0; rot_ofs <= '0;
            parts_used <= used; part_error <= err_flag | used_err;
            vertex_total <= vertex_count; edge_total <= edge_tally;
            cut_total <= cut_count; weighted_cut_total <= cut_weight_sum;
            local_cut_peak <= '0; weighted_local_cut_peak <= '0;
            least_vertices <= '0; most_vertices <= '0;
            least_edge_load <= '0; most_edge_load <= '0;
          end
        end
        ST_SCAN: begin
          if (32'(cnt) < 32'(parts_used)) begin
            if (cnt == '0 || recs[0].vertices < least_vertices)
              least_vertices <= recs[0].vertices;
            if (cnt == '0 || recs[0].vertices > most_vertices)
              most_vertices <= recs[0].vertices;
            if (cnt == '0 || es < least_edge_load) least_edge_load <= es;
            if (cnt == '0 || es > most_edge_load) most_edge_load <= es;
            if (lc > local_cut_peak) local_cut_peak <= lc;
            if ($signed(wlc) > $signed(weighted_local_cut_peak))
              weighted_local_cut_peak <= wlc;
          end
          rot_ofs <= rot_ofs + 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(MAX_PARTS - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          rot_ofs <= '0;
          strobe <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/gpcs_cell.sv
// one part's counters; shifts to its neighbour when the chain rotates
`timescale 1ns / 1ps
`default_nettype none
module gpcs_cell #(
  parameter int IdxW = 6,
  parameter int Idx  = 0
) (
  input  wire                    clk,
  input  wire gpcs_pkg::cell_cmd_t cmd,
  input  wire [IdxW-1:0]         rot_ofs,
  input  wire gpcs_pkg::part_rec_t prev,
  output gpcs_pkg::part_rec_t    rec
);
  import gpcs_pkg::*;
  logic [IdxW-1:0] slot;
  logic hit_p, hit_s, hit_d;
  // the cell holds part (Idx + rot_ofs) while the chain is rotated
  assign slot  = IdxW'(Idx) + rot_ofs;
  assign hit_p = (IdxW'(cmd.p) == slot) && (cmd.p < 6'(1 << IdxW) || IdxW >= 6);
  assign hit_s = (IdxW'(cmd.s) == slot) && (cmd.s < 6'(1 << IdxW) || IdxW >= 6);
  assign hit_d = (IdxW'(cmd.d) == slot) && (cmd.d < 6'(1 << IdxW) || IdxW >= 6);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      rec <= '0;
    end else if (cmd.rot) begin
      rec <= prev;
    end else begin
      if (cmd.vtx && hit_p) rec.vertices <= inc32(rec.vertices);
      if (cmd.edge_int && hit_s) rec.internal <= inc32(rec.internal);
      if (cmd.cut_edge && hit_s) begin
        rec.outgoing <= inc32(rec.outgoing);
        rec.wout     <= sadd64(rec.wout, cmd.w);
      end
      if (cmd.cut_edge && hit_d) begin
        rec.incoming <= inc32(rec.incoming);
        rec.win      <= sadd64(rec.win, cmd.w);
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/gpcs_checker.sv
// port-level checks for the partition cut statistics unit
`timescale 1ns / 1ps
`default_nettype none
module gpcs_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire [1:0]  op,
  input wire        strobe,
  input wire        part_error,
  input wire [6:0]  parts_used
);
  import gpcs_pkg::*;
  a_rst_idle: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("busy or strobe after reset");
  a_strobe_single: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("strobe longer than one cycle");
  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_REPORT |=> busy)
    else $error("report request did not raise busy");
  a_nopart_err: assert property (@(posedge clk) disable iff (rst)
    strobe && parts_used == 7'd0 |-> part_error)
    else $error("no parts without part_error");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("strobe while busy");
endmodule

bind graph_partition_cut_stats_unit gpcs_checker u_gpcs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .strobe(strobe),
  .part_error(part_error), .parts_used(parts_used)
);
`default_nettype wire
